// File: design/fcbf_pkg.sv
`default_nettype none

package fcbf_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int CAP_W           = 13;
    localparam int CNT_W           = 13;
    localparam int BYTE_W          = 8;
    localparam int TOT_W           = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_CLOSE = 3'd2,
        CMD_ERROR = 3'd3,
        CMD_QUERY = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [BYTE_W-1:0] push_byte;
        logic [CNT_W-1:0]  pop_count;
    } t_in_item;

    typedef struct packed {
        logic              push_accepted;
        logic [BYTE_W-1:0] front_byte;
        logic              front_valid;
        logic [CNT_W-1:0]  buffered;
        logic [CNT_W-1:0]  available;
        logic [TOT_W-1:0]  pushed_total;
        logic [TOT_W-1:0]  popped_total;
        logic              closed;
        logic              finished;
        logic              error;
    } t_out_item;

endpackage

`default_nettype wire

// File: design/fcbf_ram.sv
`default_nettype none

module fcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/flow_controlled_byte_fifo_top.sv
// Channel   Handshake                       Payload
// command   start high, busy low            i_item (t_in_item)
// result    o_result_valid, one cycle       o_result (t_out_item)
// config    i_cfg_valid and o_cfg_ready     i_cfg_data (capacity)
//
// The result appears in the cycle after the transfer, and a new command can
// be taken in that same cycle. The pointer and count update and the byte
// store write happen at the command edge; the store's registered read of the
// new front entry gives the front byte, except after a push into an empty
// buffer, which forwards the pushed byte. Reset is synchronous and active
// low; the store is not cleared. The receiver cannot stall, so busy never rises.
`default_nettype none

module flow_controlled_byte_fifo_top
    import fcbf_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_in_item         i_item,
    output logic                  o_result_valid,
    output t_out_item             o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CAP_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam int XW = (FW > CNT_W) ? FW : CNT_W;

    logic [AW-1:0]     r_rp, n_rp;
    logic [AW-1:0]     r_wp, n_wp;
    logic [FW-1:0]     r_fill, n_fill;
    logic [TOT_W-1:0]  r_pushed, n_pushed;
    logic [TOT_W-1:0]  r_popped, n_popped;
    logic              r_closed, n_closed;
    logic              r_error, n_error;
    logic [CAP_W-1:0]  r_cap;
    logic              r_out_valid;
    t_out_item         r_out, n_out;
    logic              r_fwd, n_fwd;
    logic [BYTE_W-1:0] r_fwd_byte;

    logic              accept;
    logic              push_ok;
    logic [XW-1:0]     cap_eff;
    logic [XW-1:0]     fill_x;
    logic [XW-1:0]     pop_n;
    logic [XW-1:0]     fill_next_x;
    logic [AW:0]       rp_sum;
    logic [BYTE_W-1:0] ram_rdata;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    assign cap_eff = (XW'(r_cap) > XW'(STORE_DEPTH)) ? XW'(STORE_DEPTH) : XW'(r_cap);
    assign fill_x  = XW'(r_fill);

    always_comb begin
        push_ok  = 1'b0;
        pop_n    = '0;
        n_closed = r_closed;
        n_error  = r_error;
        unique case (t_cmd'(i_item.cmd))
            CMD_PUSH: begin
                push_ok = !r_closed && (fill_x < cap_eff);
            end
            CMD_POP: begin
                pop_n = (XW'(i_item.pop_count) < fill_x) ? XW'(i_item.pop_count) : fill_x;
            end
            CMD_CLOSE: begin
                n_closed = 1'b1;
            end
            CMD_ERROR: begin
                n_error = 1'b1;
            end
            default: begin
            end
        endcase

        // The pop amount never exceeds the depth, so one subtract wraps the sum.
        rp_sum = {1'b0, r_rp} + (AW + 1)'(pop_n);
        if (rp_sum >= (AW + 1)'(STORE_DEPTH)) begin
            n_rp = AW'(rp_sum - (AW + 1)'(STORE_DEPTH));
        end else begin
            n_rp = AW'(rp_sum);
        end

        if (!push_ok) begin
            n_wp = r_wp;
        end else if (r_wp == AW'(STORE_DEPTH - 1)) begin
            n_wp = '0;
        end else begin
            n_wp = r_wp + AW'(1);
        end

        fill_next_x = fill_x + XW'(push_ok) - pop_n;
        n_fill      = FW'(fill_next_x);
        n_pushed    = r_pushed + TOT_W'(push_ok);
        n_popped    = r_popped + TOT_W'(pop_n);

        // A push into an empty buffer becomes the front byte in the same step.
        n_fwd = push_ok && (r_fill == '0);

        n_out               = r_out;
        n_out.push_accepted = push_ok;
        n_out.front_byte    = '0;
        n_out.front_valid   = (fill_next_x != '0);
        n_out.buffered      = CNT_W'(fill_next_x);
        n_out.available     = (cap_eff > fill_next_x) ? CNT_W'(cap_eff - fill_next_x) : '0;
        n_out.pushed_total  = n_pushed;
        n_out.popped_total  = n_popped;
        n_out.closed        = n_closed;
        n_out.finished      = n_closed && (fill_next_x == '0);
        n_out.error         = n_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp        <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_pushed    <= '0;
            r_popped    <= '0;
            r_closed    <= 1'b0;
            r_error     <= 1'b0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            r_out_valid <= accept;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_rp     <= n_rp;
                r_wp     <= n_wp;
                r_fill   <= n_fill;
                r_pushed <= n_pushed;
                r_popped <= n_popped;
                r_closed <= n_closed;
                r_error  <= n_error;
                r_fwd    <= n_fwd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out      <= n_out;
            r_fwd_byte <= i_item.push_byte;
        end
    end

    fcbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && push_ok),
        .i_waddr (r_wp),
        .i_wdata (i_item.push_byte),
        .i_re    (accept),
        .i_raddr (n_rp),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        o_result = r_out;
        if (!r_out.front_valid) begin
            o_result.front_byte = '0;
        end else if (r_fwd) begin
            o_result.front_byte = r_fwd_byte;
        end else begin
            o_result.front_byte = ram_rdata;
        end
    end

    assign o_result_valid = r_out_valid;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_result_valid)
        else $error("command transfer without a result in the next cycle");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_result_valid)
        else $error("result strobe without a command transfer");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_fill) <= XW'(STORE_DEPTH))
        else $error("fill count above store depth");

    a_finished_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_result.finished && o_result.front_valid))
        else $error("finished reported while bytes are buffered");

endmodule

`default_nettype wire
